[hw/rtl/pbss_pkg.sv]
// package: shared constants, command and status types for the slot selector
`default_nettype none
package pbss_pkg;

    localparam int MAX_SLOTS  = 16;
    localparam int COORD_BITS = 12;
    localparam int IDX_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);

    // divider geometry: numerator up to diff*6553600, denominator up to den*bin_width
    localparam int NUM_W  = 56;
    localparam int DEN_W  = 48;
    localparam int STEP_W = $clog2(NUM_W + 1);

    localparam logic [31:0] GRID_STRIDE = 32'd100000;
    localparam logic [15:0] MIN_BIN_W   = 16'd26;
    localparam logic [14:0] BIN_SAT     = 15'h7FFF;

    // configuration register indexes
    localparam logic [2:0] REG_SLOT_LIMIT    = 3'd0;
    localparam logic [2:0] REG_BIN_WIDTH     = 3'd1;
    localparam logic [2:0] REG_EPSILON       = 3'd2;
    localparam logic [2:0] REG_ANCHOR_FIRST  = 3'd3;
    localparam logic [2:0] REG_FIXED_ANCHOR  = 3'd4;

    // datapath operations issued by the controller
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_ACCEPT = 4'd1;
    localparam logic [3:0] OP_REUSE  = 4'd2;
    localparam logic [3:0] OP_PREP   = 4'd3;
    localparam logic [3:0] OP_MUL    = 4'd4;
    localparam logic [3:0] OP_DIVB   = 4'd5;
    localparam logic [3:0] OP_STB    = 4'd6;
    localparam logic [3:0] OP_DIVP   = 4'd7;
    localparam logic [3:0] OP_STP    = 4'd8;
    localparam logic [3:0] OP_KEY    = 4'd9;
    localparam logic [3:0] OP_DEC    = 4'd10;
    localparam logic [3:0] OP_LOOK   = 4'd11;
    localparam logic [3:0] OP_SCAN   = 4'd12;
    localparam logic [3:0] OP_COMMIT = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic       axis;
    } cmd_t;

    typedef struct packed {
        logic reuse;
        logic mode2d;
        logic div_done;
        logic hit;
        logic at_cap;
        logic scan_last;
    } status_t;

    // lowest set bit position
    function automatic logic [IDX_W-1:0] first_set(input logic [MAX_SLOTS-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/sel_in_if.sv]
// interface: input item channel
`default_nettype none
interface sel_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] sample_value;
    logic [11:0]        row;
    logic [11:0]        col;
    logic               prefer_last;

    modport source (output valid, mode, sample_value, row, col, prefer_last, input ready);
    modport sink   (input valid, mode, sample_value, row, col, prefer_last, output ready);
endinterface
`default_nettype wire

[hw/rtl/sel_out_if.sv]
// interface: result item channel
`default_nettype none
interface sel_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] slot_key;
    logic [3:0]  slot_index;
    logic        created;
    logic        reused_last;
    logic        used_fallback;
    logic [31:0] missing_key;
    logic [31:0] axis_delta_pct;
    logic        table_full;

    modport source (output valid, slot_key, slot_index, created, reused_last, used_fallback,
                    missing_key, axis_delta_pct, table_full, input ready);
    modport sink   (input valid, slot_key, slot_index, created, reused_last, used_fallback,
                    missing_key, axis_delta_pct, table_full, output ready);
endinterface
`default_nettype wire

[hw/rtl/sel_cfg_if.sv]
// interface: configuration write channel
`default_nettype none
interface sel_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [31:0] write_data;

    modport source (output valid, reg_index, write_data, input ready);
    modport sink   (input valid, reg_index, write_data, output ready);
endinterface
`default_nettype wire

[hw/rtl/pbss_div.sv]
// module: restoring divider, one quotient bit per cycle
`default_nettype none
module pbss_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pbss_pkg::NUM_W-1:0] num,
    input  wire logic [pbss_pkg::DEN_W-1:0] den,
    output logic                            done,
    output logic [pbss_pkg::NUM_W-1:0]      quo
);
    import pbss_pkg::*;

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    sub;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        sub   = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

[hw/rtl/pbss_datapath.sv]
// module: datapath with config, anchors, slot table, binning arithmetic and result registers
`default_nettype none
module pbss_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pbss_pkg::cmd_t     cmd,
    output pbss_pkg::status_t       st,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_mode,
    input  wire logic signed [31:0] in_sample,
    input  wire logic [11:0]        in_row,
    input  wire logic [11:0]        in_col,
    input  wire logic               in_prefer,
    output logic [31:0]             o_slot_key,
    output logic [3:0]              o_slot_index,
    output logic                    o_created,
    output logic                    o_reused_last,
    output logic                    o_used_fallback,
    output logic [31:0]             o_missing_key,
    output logic [31:0]             o_axis_delta_pct,
    output logic                    o_table_full
);
    import pbss_pkg::*;

    // configuration
    logic [4:0]  slot_limit_reg;
    logic [15:0] bin_width_reg;
    logic [31:0] epsilon_reg;
    logic        anchor_first_reg;
    logic [31:0] fixed_anchor_reg;

    // persistent state
    logic [31:0]          key_store_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] key_valid_reg;
    logic [31:0]          last_key_reg;
    logic                 last_key_valid_reg;
    logic [31:0]          s_anchor_reg;
    logic                 s_anchor_set_reg;
    logic [COORD_BITS-1:0] g_row_reg;
    logic [COORD_BITS-1:0] g_col_reg;
    logic                 g_set_reg;

    // item and work registers
    logic                  mode_reg;
    logic [31:0]           sample_reg;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic                  reuse_reg;
    logic [IDX_W-1:0]      reuse_idx_reg;
    logic [31:0]           diff_reg;
    logic [31:0]           den_reg;
    logic [DEN_W-1:0]      bden_reg;
    logic [38:0]           e100_reg;
    logic [14:0]           bin0_reg;
    logic [14:0]           bin1_reg;
    logic [31:0]           pct0_reg;
    logic [31:0]           pct1_reg;
    logic [31:0]           desired_reg;
    logic [31:0]           pct_reg;
    logic [31:0]           key_reg;
    logic                  fallback_reg;
    logic                  at_cap_reg;
    logic                  tfull_reg;
    logic [IDX_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      min_idx_reg;
    logic [31:0]           min_key_reg;
    logic                  min_found_reg;

    // result staging
    logic [31:0]      res_key_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic             res_created_reg;
    logic             res_reused_reg;
    logic             res_fb_reg;
    logic [31:0]      res_missing_reg;
    logic [31:0]      res_delta_reg;
    logic             res_full_reg;

    // divider hookup
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;

    pbss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        div_start = (cmd.op == OP_DIVB) || (cmd.op == OP_DIVP);
        if (cmd.op == OP_DIVB)
        begin
            div_num = NUM_W'({e100_reg, 8'b0});
            div_den = bden_reg;
        end
        else
        begin
            div_num = NUM_W'({e100_reg, 16'b0});
            div_den = DEN_W'(den_reg);
        end
    end

    // table matches
    logic [MAX_SLOTS-1:0] last_match;
    logic [MAX_SLOTS-1:0] des_match;
    logic [MAX_SLOTS-1:0] key_match;

    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            last_match[i] = key_valid_reg[i] && (key_store_reg[i] == last_key_reg);
            des_match[i]  = key_valid_reg[i] && (key_store_reg[i] == desired_reg);
            key_match[i]  = key_valid_reg[i] && (key_store_reg[i] == key_reg);
        end
    end

    // distance and denominator for one axis
    logic [31:0]           eps_q;
    logic signed [31:0]    anchor_s;
    logic [31:0]           anchor_mag;
    logic signed [32:0]    sdiff;
    logic [32:0]           sdiff_abs;
    logic [COORD_BITS-1:0] c_val;
    logic [COORD_BITS-1:0] c_anc;
    logic [COORD_BITS-1:0] c_diff;
    logic [31:0]           g_den;
    logic [31:0]           prep_diff;
    logic [31:0]           prep_den;

    always_comb
    begin
        eps_q      = (epsilon_reg == 32'd0) ? 32'd1 : epsilon_reg;
        anchor_s   = s_anchor_set_reg ? s_anchor_reg : fixed_anchor_reg;
        anchor_mag = anchor_s[31] ? (~anchor_s + 32'd1) : anchor_s;
        sdiff      = {sample_reg[31], sample_reg} - {anchor_s[31], anchor_s};
        sdiff_abs  = sdiff[32] ? (~sdiff + 33'd1) : sdiff;
        c_val      = cmd.axis ? col_reg : row_reg;
        c_anc      = cmd.axis ? g_col_reg : g_row_reg;
        c_diff     = (c_val > c_anc) ? (c_val - c_anc) : (c_anc - c_val);
        g_den      = 32'({c_anc, 16'b0});
        if (mode_reg)
        begin
            prep_diff = 32'({c_diff, 16'b0});
            prep_den  = (g_den > eps_q) ? g_den : eps_q;
        end
        else
        begin
            prep_diff = sdiff_abs[31:0];
            prep_den  = (anchor_mag > eps_q) ? anchor_mag : eps_q;
        end
    end

    logic [15:0] bw_q;
    assign bw_q = (bin_width_reg < MIN_BIN_W) ? MIN_BIN_W : bin_width_reg;

    // quotient saturation
    logic [14:0] q_bin;
    logic [31:0] q_pct;
    assign q_bin = (div_quo > NUM_W'(BIN_SAT)) ? BIN_SAT : div_quo[14:0];
    assign q_pct = (div_quo > NUM_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : div_quo[31:0];

    // key formation
    logic [31:0] row_term;
    assign row_term = 32'(bin0_reg) * GRID_STRIDE;

    // fallback decision
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cap;
    logic             at_cap;
    logic             out_dom;
    logic             fallback;
    logic [31:0]      lim_m1;
    logic [31:0]      fb_key;

    always_comb
    begin
        count    = CNT_W'($countones(key_valid_reg));
        cap      = ((slot_limit_reg != 5'd0) && (32'(slot_limit_reg) < 32'(MAX_SLOTS)))
                   ? CNT_W'(slot_limit_reg) : CNT_W'(MAX_SLOTS);
        at_cap   = count >= cap;
        out_dom  = (slot_limit_reg != 5'd0) &&
                   ((bin0_reg >= 15'(slot_limit_reg)) ||
                    (mode_reg && (bin1_reg >= 15'(slot_limit_reg))));
        fallback = out_dom || ((slot_limit_reg != 5'd0) && at_cap && !(|des_match));
        lim_m1   = 32'(slot_limit_reg - 5'd1);
        fb_key   = mode_reg ? (lim_m1 * GRID_STRIDE + lim_m1) : lim_m1;
    end

    // smallest-key scan step
    logic [31:0]      scan_key;
    logic             scan_better;
    logic [IDX_W-1:0] min_idx_n;
    logic [31:0]      min_key_n;

    always_comb
    begin
        scan_key    = key_store_reg[scan_idx_reg];
        scan_better = key_valid_reg[scan_idx_reg] && (!min_found_reg || (scan_key < min_key_reg));
        min_idx_n   = scan_better ? scan_idx_reg : min_idx_reg;
        min_key_n   = scan_better ? scan_key : min_key_reg;
    end

    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    assign hit_idx  = first_set(key_match);
    assign free_idx = first_set(~key_valid_reg);

    // control state: config, table valid bits, anchors, last key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit_reg     <= 5'd0;
            bin_width_reg      <= 16'd2560;
            epsilon_reg        <= 32'd65536;
            anchor_first_reg   <= 1'b1;
            fixed_anchor_reg   <= 32'd0;
            key_valid_reg      <= '0;
            last_key_reg       <= 32'd0;
            last_key_valid_reg <= 1'b0;
            s_anchor_reg       <= 32'd0;
            s_anchor_set_reg   <= 1'b0;
            g_row_reg          <= '0;
            g_col_reg          <= '0;
            g_set_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SLOT_LIMIT:   slot_limit_reg   <= cfg_data[4:0];
                    REG_BIN_WIDTH:    bin_width_reg    <= cfg_data[15:0];
                    REG_EPSILON:      epsilon_reg      <= cfg_data;
                    REG_ANCHOR_FIRST: anchor_first_reg <= cfg_data[0];
                    REG_FIXED_ANCHOR: fixed_anchor_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_ACCEPT)
            begin
                if (!in_mode)
                begin
                    if (!s_anchor_set_reg && anchor_first_reg)
                    begin
                        s_anchor_reg     <= in_sample;
                        s_anchor_set_reg <= 1'b1;
                    end
                end
                else if (!g_set_reg)
                begin
                    g_row_reg <= in_row[COORD_BITS-1:0];
                    g_col_reg <= in_col[COORD_BITS-1:0];
                    g_set_reg <= 1'b1;
                end
            end
            if (cmd.op == OP_LOOK)
            begin
                if (|key_match)
                begin
                    last_key_reg       <= key_reg;
                    last_key_valid_reg <= 1'b1;
                end
                else if (!at_cap_reg)
                begin
                    key_valid_reg[free_idx] <= 1'b1;
                    last_key_reg            <= key_reg;
                    last_key_valid_reg      <= 1'b1;
                end
            end
            if ((cmd.op == OP_SCAN) && (scan_idx_reg == IDX_W'(MAX_SLOTS - 1)))
            begin
                last_key_reg       <= min_key_n;
                last_key_valid_reg <= 1'b1;
            end
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                mode_reg      <= in_mode;
                sample_reg    <= in_sample;
                row_reg       <= in_row[COORD_BITS-1:0];
                col_reg       <= in_col[COORD_BITS-1:0];
                reuse_reg     <= in_prefer && last_key_valid_reg && (|last_match);
                reuse_idx_reg <= first_set(last_match);
            end
            OP_REUSE:
            begin
                res_key_reg     <= last_key_reg;
                res_idx_reg     <= reuse_idx_reg;
                res_created_reg <= 1'b0;
                res_reused_reg  <= 1'b1;
                res_fb_reg      <= 1'b0;
                res_missing_reg <= 32'd0;
                res_delta_reg   <= 32'd0;
                res_full_reg    <= 1'b0;
            end
            OP_PREP:
            begin
                diff_reg <= prep_diff;
                den_reg  <= prep_den;
            end
            OP_MUL:
            begin
                bden_reg <= DEN_W'(den_reg * bw_q);
                e100_reg <= 39'(diff_reg) * 39'd100;
            end
            OP_STB:
            begin
                if (div_done)
                begin
                    if (cmd.axis)
                    begin
                        bin1_reg <= q_bin;
                    end
                    else
                    begin
                        bin0_reg <= q_bin;
                    end
                end
            end
            OP_STP:
            begin
                if (div_done)
                begin
                    if (cmd.axis)
                    begin
                        pct1_reg <= q_pct;
                    end
                    else
                    begin
                        pct0_reg <= q_pct;
                    end
                end
            end
            OP_KEY:
            begin
                desired_reg <= mode_reg ? (row_term + 32'(bin1_reg)) : 32'(bin0_reg);
                pct_reg     <= (mode_reg && (pct1_reg > pct0_reg)) ? pct1_reg : pct0_reg;
            end
            OP_DEC:
            begin
                fallback_reg <= fallback;
                key_reg      <= fallback ? fb_key : desired_reg;
                at_cap_reg   <= at_cap;
                tfull_reg    <= (slot_limit_reg == 5'd0) && (count >= CNT_W'(MAX_SLOTS));
            end
            OP_LOOK:
            begin
                res_key_reg     <= key_reg;
                res_created_reg <= !(|key_match);
                res_reused_reg  <= 1'b0;
                res_fb_reg      <= fallback_reg;
                res_missing_reg <= fallback_reg ? desired_reg : 32'd0;
                res_delta_reg   <= fallback_reg ? pct_reg : 32'd0;
                res_full_reg    <= tfull_reg;
                scan_idx_reg    <= '0;
                min_found_reg   <= 1'b0;
                if (|key_match)
                begin
                    res_idx_reg <= hit_idx;
                end
                else
                begin
                    res_idx_reg <= free_idx;
                    if (!at_cap_reg)
                    begin
                        key_store_reg[free_idx] <= key_reg;
                    end
                end
            end
            OP_SCAN:
            begin
                scan_idx_reg    <= scan_idx_reg + 1'b1;
                min_idx_reg     <= min_idx_n;
                min_key_reg     <= min_key_n;
                min_found_reg   <= min_found_reg || scan_better;
                res_key_reg     <= min_key_n;
                res_idx_reg     <= min_idx_n;
                res_created_reg <= 1'b0;
            end
            OP_COMMIT:
            begin
                o_slot_key       <= res_key_reg;
                o_slot_index     <= 4'(res_idx_reg);
                o_created        <= res_created_reg;
                o_reused_last    <= res_reused_reg;
                o_used_fallback  <= res_fb_reg;
                o_missing_key    <= res_missing_reg;
                o_axis_delta_pct <= res_delta_reg;
                o_table_full     <= res_full_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        st.reuse     = reuse_reg;
        st.mode2d    = mode_reg;
        st.div_done  = div_done;
        st.hit       = |key_match;
        st.at_cap    = at_cap_reg;
        st.scan_last = scan_idx_reg == IDX_W'(MAX_SLOTS - 1);
    end
endmodule
`default_nettype wire

[hw/rtl/pbss_ctrl.sv]
// module: sequencing state machine and output beat valid
`default_nettype none
module pbss_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire pbss_pkg::status_t st,
    output pbss_pkg::cmd_t         cmd
);
    import pbss_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_PREP   = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_DIVB   = 4'd4;
    localparam logic [3:0] S_WB     = 4'd5;
    localparam logic [3:0] S_DIVP   = 4'd6;
    localparam logic [3:0] S_WP     = 4'd7;
    localparam logic [3:0] S_KEY    = 4'd8;
    localparam logic [3:0] S_DEC    = 4'd9;
    localparam logic [3:0] S_LOOK   = 4'd10;
    localparam logic [3:0] S_SCAN   = 4'd11;
    localparam logic [3:0] S_COMMIT = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       axis_reg;
    logic       axis_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.axis       = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                axis_next = 1'b0;
                if (st.reuse)
                begin
                    cmd.op     = OP_REUSE;
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_DIVB;
            end
            S_DIVB:
            begin
                cmd.op     = OP_DIVB;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.op = OP_STB;
                if (st.div_done)
                begin
                    state_next = S_DIVP;
                end
            end
            S_DIVP:
            begin
                cmd.op     = OP_DIVP;
                state_next = S_WP;
            end
            S_WP:
            begin
                cmd.op = OP_STP;
                if (st.div_done)
                begin
                    if (!axis_reg && st.mode2d)
                    begin
                        axis_next  = 1'b1;
                        state_next = S_PREP;
                    end
                    else
                    begin
                        state_next = S_KEY;
                    end
                end
            end
            S_KEY:
            begin
                cmd.op     = OP_KEY;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                cmd.op     = OP_DEC;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.op     = OP_LOOK;
                state_next = (st.hit || !st.at_cap) ? S_COMMIT : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (st.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_COMMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

[hw/rtl/percent_bin_slot_selector_top.sv]
// top level: percent-bin slot selector, controller plus datapath
// one beat in flight: input ready only while idle; a last-slot reuse beat skips the divides
//   and the smallest-key scan, which runs only when the key misses the table at the slot cap
// the next beat is taken after the previous result is committed, and later while the output
//   beat waits; each axis runs two divides of 56 quotient bits on the single divider
// reset: rst_n async low clears config to defaults, slot valid bits, anchors and last key
`default_nettype none
module percent_bin_slot_selector_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sel_in_if.sink     in_ch,
    sel_out_if.source  out_ch,
    sel_cfg_if.sink    cfg_ch
);
    import pbss_pkg::*;

    cmd_t    cmd;
    status_t st;

    // config writes are taken at any time; software only writes while idle
    assign cfg_ch.ready = 1'b1;

    // sequencer: owns input ready and output beat valid
    pbss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: anchors, binning divides, slot table, result registers
    pbss_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .cfg_we           (cfg_ch.valid),
        .cfg_index        (cfg_ch.reg_index),
        .cfg_data         (cfg_ch.write_data),
        .in_mode          (in_ch.mode),
        .in_sample        (in_ch.sample_value),
        .in_row           (in_ch.row),
        .in_col           (in_ch.col),
        .in_prefer        (in_ch.prefer_last),
        .o_slot_key       (out_ch.slot_key),
        .o_slot_index     (out_ch.slot_index),
        .o_created        (out_ch.created),
        .o_reused_last    (out_ch.reused_last),
        .o_used_fallback  (out_ch.used_fallback),
        .o_missing_key    (out_ch.missing_key),
        .o_axis_delta_pct (out_ch.axis_delta_pct),
        .o_table_full     (out_ch.table_full)
    );
endmodule
`default_nettype wire

[dv/pbss_tb_if.sv]
// testbench-side note: channel interfaces come from the rtl folder; this file holds the beat types
`default_nettype none
package pbss_tb_pkg;

    typedef struct packed {
        logic        mode;
        logic [31:0] sample_value;
        logic [11:0] row;
        logic [11:0] col;
        logic        prefer_last;
    } sel_req_t;

    typedef struct packed {
        logic [31:0] slot_key;
        logic [3:0]  slot_index;
        logic        created;
        logic        reused_last;
        logic        used_fallback;
        logic [31:0] missing_key;
        logic [31:0] axis_delta_pct;
        logic        table_full;
    } sel_rsp_t;

endpackage
`default_nettype wire

[dv/pbss_checker.sv]
// checker: watches the channels, predicts each result and compares it
`default_nettype none
module pbss_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    sel_in_if         in_ch,
    sel_out_if        out_ch,
    sel_cfg_if        cfg_ch,
    output int        fail_count,
    output int        pending
);
    import pbss_pkg::*;
    import pbss_tb_pkg::*;

    logic [31:0] slot_key_tbl [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] slot_used;
    logic [31:0] prev_key;
    logic        prev_key_ok;
    logic [31:0] s_anchor;
    logic        s_anchor_ok;
    logic [11:0] g_row, g_col;
    logic        g_ok;

    logic [4:0]  lim_r;
    logic [15:0] bw_r;
    logic [31:0] eps_r;
    logic        first_r;
    logic [31:0] fix_r;

    sel_rsp_t expected_q[$];

    function automatic logic [31:0] bin_of(logic [63:0] diff, logic [63:0] den);
        logic [63:0] bw, q;
        bw = (bw_r < MIN_BIN_W) ? 64'd26 : 64'(bw_r);
        q  = (diff * 64'd25600) / (den * bw);
        return (q > 64'd32767) ? 32'd32767 : q[31:0];
    endfunction

    function automatic logic [31:0] pct_of(logic [63:0] diff, logic [63:0] den);
        logic [63:0] q;
        q = (diff * 64'd6553600) / den;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic int lookup(logic [31:0] k);
        for (int i = 0; i < MAX_SLOTS; i++)
            if (slot_used[i] && slot_key_tbl[i] == k)
                return i;
        return -1;
    endfunction

    // advances the slot table and returns the expected result beat
    function automatic sel_rsp_t select_slot(sel_req_t r);
        sel_rsp_t    o;
        logic [63:0] epsq, mag, den, diff, dr, dc, denr, denc;
        longint      a, x, d;
        logic [31:0] want, pct, k, rb, cb, pr, pc, cap;
        logic        out_dom, at_cap, fb, tfull;
        int          cnt, idx;
        o = '0;
        epsq = (eps_r == 0) ? 64'd1 : 64'(eps_r);
        if (!r.mode) begin
            if (!s_anchor_ok && first_r) begin
                s_anchor = r.sample_value;
                s_anchor_ok = 1'b1;
            end
        end else if (!g_ok) begin
            g_row = r.row;
            g_col = r.col;
            g_ok  = 1'b1;
        end
        if (r.prefer_last && prev_key_ok) begin
            idx = lookup(prev_key);
            if (idx >= 0) begin
                o.slot_key    = prev_key;
                o.slot_index  = idx[3:0];
                o.reused_last = 1'b1;
                return o;
            end
        end
        if (!r.mode) begin
            a    = longint'($signed(s_anchor_ok ? s_anchor : fix_r));
            x    = longint'($signed(r.sample_value));
            mag  = (a < 0) ? -a : a;
            den  = (mag > epsq) ? mag : epsq;
            d    = x - a;
            diff = (d < 0) ? -d : d;
            want = bin_of(diff, den);
            pct  = pct_of(diff, den);
            out_dom = lim_r > 0 && want >= lim_r;
        end else begin
            dr   = 64'((r.row > g_row) ? r.row - g_row : g_row - r.row) << 16;
            dc   = 64'((r.col > g_col) ? r.col - g_col : g_col - r.col) << 16;
            denr = (64'(g_row) << 16 > epsq) ? 64'(g_row) << 16 : epsq;
            denc = (64'(g_col) << 16 > epsq) ? 64'(g_col) << 16 : epsq;
            rb = bin_of(dr, denr);
            cb = bin_of(dc, denc);
            pr = pct_of(dr, denr);
            pc = pct_of(dc, denc);
            want = rb * GRID_STRIDE + cb;
            pct  = (pr > pc) ? pr : pc;
            out_dom = lim_r > 0 && (rb >= lim_r || cb >= lim_r);
        end
        cnt = $countones(slot_used);
        cap = (lim_r > 0 && lim_r < MAX_SLOTS) ? 32'(lim_r) : 32'(MAX_SLOTS);
        at_cap = cnt >= cap;
        tfull  = lim_r == 0 && cnt >= MAX_SLOTS;
        fb = out_dom || (lim_r > 0 && at_cap && lookup(want) < 0);
        if (fb && lim_r > 0)
            k = r.mode ? (32'(lim_r) - 1) * GRID_STRIDE + (32'(lim_r) - 1) : 32'(lim_r) - 1;
        else
            k = want;
        idx = lookup(k);
        if (idx < 0) begin
            if (at_cap)
                for (int i = 0; i < MAX_SLOTS; i++)
                    if (slot_used[i] && (idx < 0 || slot_key_tbl[i] < slot_key_tbl[idx]))
                        idx = i;
            if (idx < 0) begin
                for (int i = MAX_SLOTS - 1; i >= 0; i--)
                    if (!slot_used[i])
                        idx = i;
                if (idx < 0)
                    idx = 0;
                slot_key_tbl[idx] = k;
                slot_used[idx] = 1'b1;
                o.created = 1'b1;
            end
        end
        prev_key    = slot_key_tbl[idx];
        prev_key_ok = 1'b1;
        o.slot_key       = slot_key_tbl[idx];
        o.slot_index     = idx[3:0];
        o.used_fallback  = fb;
        o.missing_key    = fb ? want : 32'd0;
        o.axis_delta_pct = fb ? pct : 32'd0;
        o.table_full     = tfull;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sel_req_t r;
        sel_rsp_t got, exp_b;
        if (!rst_n)
        begin
            slot_used   = '0;
            prev_key    = '0;
            prev_key_ok = 1'b0;
            s_anchor    = '0;
            s_anchor_ok = 1'b0;
            g_row = '0;
            g_col = '0;
            g_ok  = 1'b0;
            lim_r = '0;
            bw_r  = 16'd2560;
            eps_r = 32'd65536;
            first_r = 1'b1;
            fix_r = '0;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.reg_index)
                    REG_SLOT_LIMIT:   lim_r   = cfg_ch.write_data[4:0];
                    REG_BIN_WIDTH:    bw_r    = cfg_ch.write_data[15:0];
                    REG_EPSILON:      eps_r   = cfg_ch.write_data;
                    REG_ANCHOR_FIRST: first_r = cfg_ch.write_data[0];
                    REG_FIXED_ANCHOR: fix_r   = cfg_ch.write_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.slot_key, out_ch.slot_index, out_ch.created, out_ch.reused_last,
                        out_ch.used_fallback, out_ch.missing_key, out_ch.axis_delta_pct,
                        out_ch.table_full};
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %p", got);
                end
                else
                begin
                    exp_b = expected_q.pop_front();
                    if (got !== exp_b)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", exp_b, got);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                r = '{in_ch.mode, in_ch.sample_value, in_ch.row, in_ch.col, in_ch.prefer_last};
                expected_q.push_back(select_slot(r));
            end
            pending = expected_q.size();
        end
    end

endmodule
`default_nettype wire

[dv/tb.sv]
// testbench top: stimulus, handshake pacing and verdict for the slot selector
`default_nettype none
module tb;
    import pbss_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count, pending;
    bit   hold_long = 1'b0;   // long receiver hold-off request
    bit   stall_on  = 1'b1;   // random receiver stalls enabled

    sel_in_if  in_ch();
    sel_out_if out_ch();
    sel_cfg_if cfg_ch();

    percent_bin_slot_selector_top DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
    );

    pbss_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // every input known from time zero
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.sample_value = '0;
        in_ch.row = '0;
        in_ch.col = '0;
        in_ch.prefer_last = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.write_data = '0;
    end

    // receiver: own stall pattern, plus a long counted hold-off when asked
    always @(posedge clk)
    begin
        if (hold_long)
            out_ch.ready <= 1'b0;
        else if (!stall_on)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // one configuration write, only while idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_ch.reg_index  <= idx;
        cfg_ch.write_data <= val;
        cfg_ch.valid      <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // one input beat; valid stays high across back-to-back beats of a burst
    task automatic send_beat(logic m, logic [31:0] v, logic [11:0] r, logic [11:0] c, logic p);
        in_ch.mode         <= m;
        in_ch.sample_value <= v;
        in_ch.row          <= r;
        in_ch.col          <= c;
        in_ch.prefer_last  <= p;
        in_ch.valid        <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic gap_cycles(int n);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // random beat: mostly values near a modest anchor so bins stay small and tables fill
    task automatic send_random;
        logic [31:0] v;
        logic [11:0] r, c;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = 32'($signed(-$urandom_range(0, 200000)));
            default: v = $urandom_range(0, 400000);
        endcase
        if ($urandom_range(0, 7) == 0)
        begin
            r = 12'($urandom());
            c = 12'($urandom());
        end
        else
        begin
            r = 12'($urandom_range(90, 140));
            c = 12'($urandom_range(90, 140));
        end
        send_beat($urandom_range(0, 2) == 0, v, r, c, $urandom_range(0, 3) == 0);
    endtask

    // wait for all results, then let the block settle before reconfiguring
    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && n > 0; i++, n--)
                send_random();
            gap_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of the fields under reset config, then fallback cases
        send_beat(1'b0, 32'h0001_0000, 12'd0, 12'd0, 1'b1);    // anchor latch at 1.0
        send_beat(1'b0, 32'h7FFF_FFFF, 12'd0, 12'd0, 1'b0);    // bin saturation
        send_beat(1'b0, 32'h8000_0000, 12'd0, 12'd0, 1'b0);
        send_beat(1'b0, 32'hFFFF_FFFF, 12'd0, 12'd0, 1'b1);    // last-slot reuse
        send_beat(1'b1, 32'd0, 12'd0, 12'd0, 1'b0);            // grid anchor at origin
        send_beat(1'b1, 32'd0, 12'hFFF, 12'hFFF, 1'b0);
        send_beat(1'b1, 32'd0, 12'hFFF, 12'd0, 1'b1);
        for (int i = 0; i < 12; i++)                          // add distinct keys to the table
            send_beat(1'b0, 32'h0001_0000 + i * 32'h0000_4000, 12'd0, 12'd0, 1'b0);
        send_beat(1'b0, 32'h0040_0000, 12'd0, 12'd0, 1'b0);    // one more new key, table still not full
        drain();

        write_reg(REG_SLOT_LIMIT, 32'd3);
        write_reg(REG_BIN_WIDTH, 32'd0);                       // floored width
        write_reg(REG_EPSILON, 32'd0);
        write_reg(REG_ANCHOR_FIRST, 32'd0);
        write_reg(REG_FIXED_ANCHOR, 32'h8000_0000);
        send_beat(1'b0, 32'h8000_0000, 12'd0, 12'd0, 1'b0);
        send_beat(1'b0, 32'h7FFF_FFFF, 12'd0, 12'd0, 1'b0);    // out-of-limit fallback
        send_beat(1'b1, 32'd0, 12'd5, 12'd9, 1'b1);
        drain();

        // random phases over several settings, extremes included; one with a long hold-off
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_SLOT_LIMIT, 32'd0); write_reg(REG_BIN_WIDTH, 32'd2560);
                   write_reg(REG_EPSILON, 32'd65536); end
                1: begin write_reg(REG_SLOT_LIMIT, 32'd16); write_reg(REG_BIN_WIDTH, 32'd65535);
                   write_reg(REG_EPSILON, 32'hFFFF_FFFF); end
                2: begin write_reg(REG_SLOT_LIMIT, 32'd5); write_reg(REG_BIN_WIDTH, 32'd26);
                   write_reg(REG_EPSILON, 32'd1); write_reg(REG_FIXED_ANCHOR, 32'h0002_0000); end
                3: begin write_reg(REG_SLOT_LIMIT, 32'd1); write_reg(REG_BIN_WIDTH, 32'd1280);
                   write_reg(REG_EPSILON, 32'd65536); write_reg(REG_FIXED_ANCHOR, 32'h7FFF_FFFF); end
                4: begin write_reg(REG_SLOT_LIMIT, 32'd8); write_reg(REG_BIN_WIDTH, 32'd5000);
                   write_reg(REG_ANCHOR_FIRST, 32'd1); end
                default: begin write_reg(REG_SLOT_LIMIT, 32'd12); write_reg(REG_BIN_WIDTH, 32'd700); end
            endcase
            stall_on = (ph != 4);
            if (ph == 2)
            begin
                // long hold-off: sender keeps offering while results back up
                fork
                    begin
                        hold_long = 1'b1;
                        for (int c = 0; c < 2000; c++) @(posedge clk);
                        hold_long = 1'b0;
                    end
                    random_phase(270);
                join
            end
            else
                random_phase(270);
            drain();
        end

        if (fail_count == 0)
            $display("percent_bin_slot_selector_top regression: pass");
        else
            $display("percent_bin_slot_selector_top regression: fail");
        $finish;
    end

    // slowest run: ~1700 beats with block time, gaps and stalls, well under this
    initial
    begin
        #40000000;
        $display("percent_bin_slot_selector_top regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
